>>> design/message_ring_queue_macros.svh
// assertion macros for the message ring queue
`ifndef MESSAGE_RING_QUEUE_MACROS_SVH
`define MESSAGE_RING_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define MRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define MRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRQ_ASSERT_NOW(lbl, ante, cons, msg)
`define MRQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/mrq_pkg.sv
// shared types and constants of the message ring queue
package mrq_pkg;

    localparam int MAX_SLOTS_DEF         = 16;
    localparam int MAX_MESSAGE_BYTES_DEF = 32;
    localparam int SLOT_COUNT_RST        = 16;
    localparam int SLOT_BYTES_RST        = 32;
    localparam int CFG_DATA_W            = 6;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_PUSHED = 3'd1,
        ST_FULL   = 3'd2,
        ST_LARGE  = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_SLOT_COUNT = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte_res;
        logic [5:0]  message_length;
        logic        last;
    } res_t;

endpackage

>>> design/mrq_ram.sv
// generic simple dual-port ram with registered read
module mrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/message_ring_queue.sv
// message ring queue top level: slot pointers, push and read sequencing
//
// ring of MAX_SLOTS slots of MAX_MESSAGE_BYTES bytes each, in two rams: one for
// message bytes, one for stored lengths. a push word carries one byte and is
// taken every cycle while busy is low; the word with last_byte set returns one
// status word in the next cycle (pushed, full or too large). a release returns
// nothing. a read of an empty queue returns one empty word in the next cycle.
// a read of a stored message keeps busy high until its last data word is shown
// on res; its data words come out one per cycle, the first one registered from
// the length and byte ram outputs in the S_LEN state. results are shown for
// exactly one cycle on res, marked by res_valid, and the receiver cannot stall
// them. both rams start undefined and need no clearing pass; the queue is
// usable right after reset. cfg_ready is always high; configuration is meant
// to be written while the queue is idle, and a slot_count write drops all
// stored messages.
module message_ring_queue #(
    parameter int MAX_SLOTS         = mrq_pkg::MAX_SLOTS_DEF,
    parameter int MAX_MESSAGE_BYTES = mrq_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mrq_pkg::item_t                  item,
    output logic                            res_valid,
    output mrq_pkg::res_t                   res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  mrq_pkg::cfg_index_t             cfg_index,
    input  logic [mrq_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "message_ring_queue_macros.svh"

    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int SC_W       = $clog2(MAX_SLOTS + 1);
    localparam int LEN_W      = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int BYTE_DEPTH = MAX_SLOTS * MAX_MESSAGE_BYTES;
    localparam int ADDR_W     = $clog2(BYTE_DEPTH);
    localparam int SC_INIT    = (mrq_pkg::SLOT_COUNT_RST > MAX_SLOTS) ?
                                MAX_SLOTS : mrq_pkg::SLOT_COUNT_RST;
    localparam int SB_INIT    = (mrq_pkg::SLOT_BYTES_RST > MAX_MESSAGE_BYTES) ?
                                MAX_MESSAGE_BYTES : mrq_pkg::SLOT_BYTES_RST;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [LEN_W-1:0]    bim_reg, bim_next;      // bytes of the message being pushed
    logic                rej_reg, rej_next;      // message overflowed its slot
    logic [SC_W-1:0]     sc_reg, sc_next;
    logic [LEN_W-1:0]    sb_reg, sb_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;      // slot being streamed
    logic [LEN_W-1:0]    idx_reg, idx_next;      // byte index now on the ram output
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                res_valid_reg, res_valid_next;
    mrq_pkg::res_t       res_reg, res_next;

    // ram ports
    logic                byte_we;
    logic [ADDR_W-1:0]   byte_waddr, byte_raddr;
    logic [7:0]          byte_rdata;
    logic                len_we;
    logic [LEN_W-1:0]    len_wdata, len_rdata;

    logic                accept;
    logic [SLOT_W-1:0]   pos_c;
    logic                empty_c;
    logic                over_c;
    logic [SLOT_W-1:0]   rd_slot;
    logic [LEN_W:0]      rd_idx;
    logic [LEN_W-1:0]    len_c;
    logic                stream_last;
    logic [SC_W-1:0]     sc_cfg;
    logic [LEN_W-1:0]    sb_cfg;

    // ring increment with wrap at the slot count in use
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [SC_W-1:0]   n);
        logic [SC_W:0] inc;
        inc = (SC_W + 1)'(s) + 1'b1;
        return (inc >= {1'b0, n}) ? '0 : SLOT_W'(inc);
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;

    assign pos_c   = next_slot(head_reg, sc_reg);
    assign empty_c = (pos_c == tail_reg);
    assign over_c  = (bim_reg >= sb_reg);

    // read addressing: byte 0 on the read word, then one byte ahead each cycle
    assign rd_slot = (state_reg == S_IDLE) ? pos_c : pos_reg;
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   rd_idx = '0;
            S_LEN:    rd_idx = (LEN_W + 1)'(1);
            S_STREAM: rd_idx = {1'b0, idx_reg} + 1'b1;
            default:  rd_idx = '0;
        endcase
    end
    assign byte_raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_MESSAGE_BYTES) + ADDR_W'(rd_idx);
    assign byte_waddr = ADDR_W'(tail_reg) * ADDR_W'(MAX_MESSAGE_BYTES) + ADDR_W'(bim_reg);
    assign len_wdata  = bim_reg + 1'b1;

    // stored length clamped into 1..max
    always_comb
    begin
        if (len_rdata == '0)
        begin
            len_c = LEN_W'(1);
        end
        else if (len_rdata > LEN_W'(MAX_MESSAGE_BYTES))
        begin
            len_c = LEN_W'(MAX_MESSAGE_BYTES);
        end
        else
        begin
            len_c = len_rdata;
        end
    end

    assign stream_last = (({1'b0, idx_reg} + 1'b1) == {1'b0, len_reg});

    // saturated register values
    always_comb
    begin
        if (cfg_data[4:0] < 5'd2)
        begin
            sc_cfg = SC_W'(2);
        end
        else if (cfg_data[4:0] > MAX_SLOTS)
        begin
            sc_cfg = SC_W'(MAX_SLOTS);
        end
        else
        begin
            sc_cfg = SC_W'(cfg_data[4:0]);
        end
        if (cfg_data[5:0] == 6'd0)
        begin
            sb_cfg = LEN_W'(1);
        end
        else if (cfg_data[5:0] > MAX_MESSAGE_BYTES)
        begin
            sb_cfg = LEN_W'(MAX_MESSAGE_BYTES);
        end
        else
        begin
            sb_cfg = LEN_W'(cfg_data[5:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        bim_next       = bim_reg;
        rej_next       = rej_reg;
        sc_next        = sc_reg;
        sb_next        = sb_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        byte_we        = 1'b0;
        len_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.opcode)
                        mrq_pkg::OP_PUSH:
                        begin
                            // bytes past the slot limit are dropped
                            if (over_c)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                byte_we  = 1'b1;
                                bim_next = bim_reg + 1'b1;
                            end
                            if (item.last_byte)
                            begin
                                res_valid_next          = 1'b1;
                                res_next.data_byte_res  = '0;
                                res_next.message_length = '0;
                                res_next.last           = 1'b1;
                                // full wins over too large
                                if (tail_reg == head_reg)
                                begin
                                    res_next.status = mrq_pkg::ST_FULL;
                                end
                                else if (rej_reg || over_c)
                                begin
                                    res_next.status = mrq_pkg::ST_LARGE;
                                end
                                else
                                begin
                                    res_next.status = mrq_pkg::ST_PUSHED;
                                    len_we          = 1'b1;
                                    tail_next       = next_slot(tail_reg, sc_reg);
                                end
                                bim_next = '0;
                                rej_next = 1'b0;
                            end
                        end
                        mrq_pkg::OP_READ:
                        begin
                            if (empty_c)
                            begin
                                res_valid_next          = 1'b1;
                                res_next.status         = mrq_pkg::ST_EMPTY;
                                res_next.data_byte_res  = '0;
                                res_next.message_length = '0;
                                res_next.last           = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LEN;
                                pos_next   = pos_c;
                            end
                        end
                        mrq_pkg::OP_RELEASE:
                        begin
                            // release of an empty queue is ignored
                            if (!empty_c)
                            begin
                                head_next = pos_c;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                // length and first byte arrive together
                res_valid_next          = 1'b1;
                res_next.status         = mrq_pkg::ST_DATA;
                res_next.data_byte_res  = byte_rdata;
                res_next.message_length = 6'(len_c);
                res_next.last           = (len_c == LEN_W'(1));
                len_next                = len_c;
                idx_next                = LEN_W'(1);
                state_next              = (len_c == LEN_W'(1)) ? S_IDLE : S_STREAM;
            end
            S_STREAM:
            begin
                res_valid_next          = 1'b1;
                res_next.status         = mrq_pkg::ST_DATA;
                res_next.data_byte_res  = byte_rdata;
                res_next.message_length = 6'(len_reg);
                res_next.last           = stream_last;
                idx_next                = idx_reg + 1'b1;
                if (stream_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mrq_pkg::CFG_SLOT_COUNT:
                begin
                    sc_next   = sc_cfg;
                    head_next = SLOT_W'(sc_cfg - 1'b1);
                    tail_next = '0;
                    bim_next  = '0;
                    rej_next  = 1'b0;
                end
                mrq_pkg::CFG_SLOT_BYTES:
                begin
                    sb_next = sb_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= SLOT_W'(SC_INIT - 1);
            tail_reg      <= '0;
            bim_reg       <= '0;
            rej_reg       <= 1'b0;
            sc_reg        <= SC_W'(SC_INIT);
            sb_reg        <= LEN_W'(SB_INIT);
            pos_reg       <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            bim_reg       <= bim_next;
            rej_reg       <= rej_next;
            sc_reg        <= sc_next;
            sb_reg        <= sb_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // message bytes, slot s byte i at s * MAX_MESSAGE_BYTES + i
    mrq_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (item.data_byte),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    // stored message lengths, one per slot
    mrq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (tail_reg),
        .wdata (len_wdata),
        .raddr (rd_slot),
        .rdata (len_rdata)
    );

    `MRQ_ASSERT_NOW(a_ptr_range, 1'b1, (SC_W'(head_reg) < sc_reg) && (SC_W'(tail_reg) < sc_reg), "ring pointer beyond slot count")
    `MRQ_ASSERT_NOW(a_no_write_in_read, state_reg != S_IDLE, !byte_we && !len_we, "ram written during a read")
    `MRQ_ASSERT_NOW(a_status_is_last, res_valid_reg && (res_reg.status != mrq_pkg::ST_DATA), res_reg.last, "status word without last")
    `MRQ_ASSERT_NOW(a_last_byte_idle, res_valid_reg && res_reg.last && (res_reg.status == mrq_pkg::ST_DATA), state_reg == S_IDLE, "read still busy after last byte")
    `MRQ_ASSERT_NEXT(a_read_starts, accept && (item.opcode == mrq_pkg::OP_READ) && !empty_c && !cfg_valid, state_reg == S_LEN, "read of stored message did not start")

endmodule

>>> verif/ring_mirror_pkg.sv
// scoreboard class that mirrors the message ring queue and checks its result words
package ring_mirror_pkg;

    import mrq_pkg::*;

    localparam int SLOTS     = MAX_SLOTS_DEF;
    localparam int SLOT_SPAN = MAX_MESSAGE_BYTES_DEF;

    class ring_mirror;

        // mirrored queue contents and pointers
        bit [7:0]    slot_data [SLOTS][SLOT_SPAN];
        bit [5:0]    slot_len  [SLOTS];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        bit          rejected;
        int unsigned count_cfg;
        int unsigned bytes_cfg;

        // result words still owed by the block, oldest first
        res_t        due_results [$];

        int          fault_count;
        int          words_checked;
        int          regs_written;

        function new();
            count_cfg = SLOT_COUNT_RST;
            bytes_cfg = SLOT_BYTES_RST;
            rewind();
        endfunction

        function void rewind();
            head     = count_cfg - 1;
            tail     = 0;
            fill     = 0;
            rejected = 1'b0;
        endfunction

        function int unsigned step_slot(int unsigned s);
            return (s + 1 >= count_cfg) ? 0 : s + 1;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void owe_word(status_t st, logic [7:0] b, logic [5:0] len, logic fin);
            res_t r;
            r.status         = st;
            r.data_byte_res  = b;
            r.message_length = len;
            r.last           = fin;
            due_results.push_back(r);
        endfunction

        // register write as seen by the block; out of range values saturate
        function void set_register(cfg_index_t idx, logic [5:0] val);
            int unsigned v;
            regs_written++;
            if (idx == CFG_SLOT_COUNT) begin
                v = val[4:0];
                if (v < 2) v = 2;
                if (v > SLOTS) v = SLOTS;
                count_cfg = v;
                rewind();
            end
            else begin
                v = val;
                if (v < 1) v = 1;
                if (v > SLOT_SPAN) v = SLOT_SPAN;
                bytes_cfg = v;
            end
        endfunction

        // one accepted input word: update the mirror and queue what it returns
        function void absorb_word(item_t it);
            int unsigned pos;
            int unsigned n;
            if (head >= count_cfg) head = count_cfg - 1;
            if (tail >= count_cfg) tail = 0;
            pos = step_slot(head);
            case (it.opcode)
                OP_PUSH: begin
                    if (fill >= bytes_cfg) rejected = 1'b1;
                    else begin
                        slot_data[tail][fill] = it.data_byte;
                        fill++;
                    end
                    if (it.last_byte) begin
                        if (tail == head) owe_word(ST_FULL, 8'h00, 6'd0, 1'b1);
                        else if (rejected) owe_word(ST_LARGE, 8'h00, 6'd0, 1'b1);
                        else begin
                            slot_len[tail] = fill[5:0];
                            tail = step_slot(tail);
                            owe_word(ST_PUSHED, 8'h00, 6'd0, 1'b1);
                        end
                        fill     = 0;
                        rejected = 1'b0;
                    end
                end
                OP_READ: begin
                    if (pos == tail) owe_word(ST_EMPTY, 8'h00, 6'd0, 1'b1);
                    else begin
                        n = slot_len[pos];
                        if (n < 1) n = 1;
                        if (n > SLOT_SPAN) n = SLOT_SPAN;
                        for (int i = 0; i < n; i++)
                            owe_word(ST_DATA, slot_data[pos][i], n[5:0], (i + 1 == n));
                    end
                end
                OP_RELEASE: begin
                    if (pos != tail) head = pos;
                end
                default: ;
            endcase
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            fault_count++;
        endtask

        task check_word(res_t got);
            res_t want;
            words_checked++;
            if (due_results.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing due (status %0d)",
                                        got.status));
            end
            else begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.data_byte_res !== want.data_byte_res)
                    flag_mismatch($sformatf("data_byte_res %0h, want %0h",
                                            got.data_byte_res, want.data_byte_res));
                if (got.message_length !== want.message_length)
                    flag_mismatch($sformatf("message_length %0d, want %0d",
                                            got.message_length, want.message_length));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask

    endclass

endpackage

>>> verif/tb.sv
// top-level testbench of the message ring queue: stimulus, monitor and run control
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;
    import ring_mirror_pkg::*;

    // opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    // generous bound; a slow correct run stays well under it
    localparam int        CYCLE_LIMIT  = 300000;
    localparam int        SETTLE_WAIT  = 4;
    localparam int        DRAIN_WAIT   = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    item_t                item      = '0;
    logic                 cfg_valid = 1'b0;
    cfg_index_t           cfg_index = CFG_SLOT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                 busy;
    logic                 res_valid;
    res_t                 res;
    logic                 cfg_ready;

    ring_mirror           mirror;
    int                   words_sent;
    int                   cycles;
    // when set, the sender drives words back to back with no gaps
    bit                   burst_mode;

    message_ring_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    // result monitor: a word is taken at the edge that ends its strobe cycle
    always @(posedge clk) begin
        if (rst_n && res_valid)
            mirror.check_word(res);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped by watchdog after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // drive one word; start stays high after acceptance so that a following
    // word with no gap is taken on the very next free edge
    task automatic send_word(opcode_t op, logic [7:0] b, logic fin);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{opcode: op, data_byte: b, last_byte: fin};
        // accepted at the first edge that sees busy low
        do @(posedge clk); while (busy);
        mirror.absorb_word(item);
        if (op != opcode_t'(OP_UNUSED))
            words_sent++;
    endtask

    // push len bytes of random content; ends the message only when finish is set
    task automatic push_message(int len, bit finish);
        for (int i = 0; i < len; i++)
            send_word(OP_PUSH, 8'($urandom_range(0, 255)), finish && (i == len - 1));
    endtask

    // stop sending and let every owed word arrive, then allow for a word in flight
    // that returns nothing (a release or a middle push byte)
    task automatic settle();
        start <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // register writes only with the queue idle; valid stays high across a pair
    task automatic write_regs(bit wr_count, logic [5:0] count_val,
                              bit wr_bytes, logic [5:0] bytes_val);
        settle();
        if (wr_count) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_SLOT_COUNT;
            cfg_data  <= count_val;
            do @(posedge clk); while (!cfg_ready);
            mirror.set_register(cfg_index, cfg_data);
        end
        if (wr_bytes) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_SLOT_BYTES;
            cfg_data  <= bytes_val;
            do @(posedge clk); while (!cfg_ready);
            mirror.set_register(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly whole messages, reads and releases, with a little noise: abandoned
    // messages, the unused opcode and random values in ignored fields
    task automatic random_phase(int budget, int release_pct, int long_pct);
        int stop_at;
        int r;
        int len;
        int cap;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            // toggle between gapped traffic and back-to-back stretches
            if ($urandom_range(0, 19) == 0)
                burst_mode = ~burst_mode;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // short messages most of the time, now and then up to past the limit
                cap = (mirror.bytes_cfg < 4) ? mirror.bytes_cfg + 1 : 4;
                if ($urandom_range(0, 99) < long_pct)
                    len = $urandom_range(1, mirror.bytes_cfg + 2);
                else
                    len = $urandom_range(1, cap);
                push_message(len, $urandom_range(0, 19) != 0);
            end
            else if (r < 75)
                send_word(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (r < 75 + release_pct)
                send_word(OP_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_word(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        mirror     = new();
        words_sent = 0;
        cycles     = 0;
        burst_mode = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part, reset configuration of 16 slots and 32 bytes ---
        // read and release on an empty queue, then the unused opcode
        send_word(OP_READ, 8'h00, 1'b0);
        send_word(OP_RELEASE, 8'hFF, 1'b1);
        send_word(opcode_t'(OP_UNUSED), 8'hFF, 1'b1);
        // one-byte and two-byte messages at the byte extremes
        send_word(OP_PUSH, 8'hFF, 1'b1);
        send_word(OP_PUSH, 8'h00, 1'b0);
        send_word(OP_PUSH, 8'hA5, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0);
        send_word(OP_RELEASE, 8'h00, 1'b0);
        send_word(OP_READ, 8'hFF, 1'b1);
        send_word(OP_RELEASE, 8'h00, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0);

        // zero slot_bytes saturates to one; a two-byte message is too large
        write_regs(1'b0, 6'd0, 1'b1, 6'd0);
        send_word(OP_PUSH, 8'h5A, 1'b0);
        send_word(OP_PUSH, 8'hC3, 1'b1);

        // two slots hold one message; full beats too large
        write_regs(1'b1, 6'd2, 1'b1, 6'd1);
        send_word(OP_PUSH, 8'h3C, 1'b1);
        send_word(OP_PUSH, 8'h81, 1'b0);
        send_word(OP_PUSH, 8'h7E, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0);
        send_word(OP_RELEASE, 8'h00, 1'b0);

        // slot_bytes lowered in the middle of a message
        write_regs(1'b0, 6'd0, 1'b1, 6'd32);
        push_message(3, 1'b0);
        write_regs(1'b0, 6'd0, 1'b1, 6'd2);
        send_word(OP_PUSH, 8'h42, 1'b1);

        // slot_count write drops the partly pushed message
        send_word(OP_PUSH, 8'h99, 1'b0);
        write_regs(1'b1, 6'd5, 1'b0, 6'd0);
        send_word(OP_PUSH, 8'h24, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0);

        // --- random phases over a spread of settings ---
        // full size, few releases so the ring fills up
        write_regs(1'b1, 6'd16, 1'b1, 6'd32);
        random_phase(90, 3, 3);
        // low values saturate: two slots of one byte
        write_regs(1'b1, 6'd1, 1'b1, 6'd0);
        random_phase(60, 20, 10);
        // slot_bytes above range saturates to the maximum
        write_regs(1'b1, 6'd3, 1'b1, 6'd63);
        random_phase(70, 15, 10);
        // slot_count 63 keeps five bits, saturates to the maximum; long messages
        write_regs(1'b1, 6'd63, 1'b1, 6'd32);
        random_phase(80, 8, 25);
        // slot_count 33 keeps five bits, saturates to two
        write_regs(1'b1, 6'd33, 1'b1, 6'd5);
        random_phase(60, 15, 15);
        write_regs(1'b1, 6'd7, 1'b1, 6'd12);
        random_phase(110, 10, 10);

        // drain: everything owed, then a few quiet cycles for stray words
        start <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d input words across %0d register writes (slot counts 2 to 16)",
                 words_sent, mirror.regs_written);
        $display("checked %0d result words in %0d cycles, %0d mismatches",
                 mirror.words_checked, cycles, mirror.fault_count);
        if (mirror.fault_count == 0 && mirror.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/mrq_pkg.sv
design/mrq_ram.sv
design/message_ring_queue.sv
verif/ring_mirror_pkg.sv
verif/tb.sv
